// ===== rtl/core/crvg_pkg.sv =====
// shared types, constants and helper functions for the circle ring vertex generator
// no dependencies; used by every module of the block except crvg_assertions by scoped names
`default_nettype none

package crvg_pkg;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int MAX_RINGS        = 256;

    localparam int PIPE_DEPTH = 6;

    localparam int COORD_W     = 16;
    localparam int RING_W      = 8;
    localparam int VERTEX_W    = 12;
    localparam int PHASE_W     = 12;
    localparam int OFFSET_W    = 10;
    localparam int RADIUS_W    = 21;
    localparam int SIN_VAL_W   = 16;
    localparam int SIN_MAG_W   = 15;
    localparam int SIN_IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [PHASE_W-1:0] PHASE_QUARTER = PHASE_W'(1024);
    localparam logic [63:0]        PI_HALF_Q30   = 64'd1686629713;
    localparam logic signed [63:0] ONE_Q14       = 64'sd16384;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CENTER_X     = 3'd0,
        CFG_CENTER_Y     = 3'd1,
        CFG_BASE_RADIUS  = 3'd2,
        CFG_RING_STEP    = 3'd3,
        CFG_ASPECT_RATIO = 3'd4,
        CFG_ANGLE_STEP   = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic [14:0]        base_radius;
        logic [11:0]        ring_step;
        logic [15:0]        aspect_ratio;
        logic [11:0]        angle_step;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        center_x:     16'sd0,
        center_y:     16'sd0,
        base_radius:  15'd8192,
        ring_step:    12'd41,
        aspect_ratio: 16'd4096,
        angle_step:   12'd128
    };

    typedef logic [SIN_MAG_W-1:0] sine_mag_t;
    typedef sine_mag_t [SINE_TABLE_DEPTH:0] sine_rom_t;

    // unsigned long division by shift and subtract
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // quarter-wave sine in q14, taylor series to x^17 in q30
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t          rom;
        logic [63:0]        a;
        logic [63:0]        a2;
        logic [63:0]        term;
        logic [63:0]        divisor;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
        begin
            a    = div_u64(PI_HALF_Q30 * 64'(k) + 64'(SINE_TABLE_DEPTH / 2),
                           64'(SINE_TABLE_DEPTH));
            a2   = (a * a) >> 30;
            term = a;
            sum  = signed'(a);
            for (int n = 1; n <= 8; n++)
            begin
                divisor = 64'((2 * n) * (2 * n + 1));
                term    = div_u64((term * a2) >> 30, divisor);
                if ((n % 2) == 1)
                begin
                    sum = sum - signed'(term);
                end
                else
                begin
                    sum = sum + signed'(term);
                end
            end
            if (sum < 0)
            begin
                sum = 64'sd0;
            end
            v = (sum + 64'sd32768) >>> 16;
            if (v > ONE_Q14)
            begin
                v = ONE_Q14;
            end
            rom[k] = SIN_MAG_W'(v);
        end
        return rom;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [31:0] v);
        logic signed [COORD_W-1:0] res;
        if (v > 32'sd32767)
        begin
            res = 16'sh7fff;
        end
        else if (v < -32'sd32768)
        begin
            res = 16'sh8000;
        end
        else
        begin
            res = COORD_W'(v);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/crvg_front.sv =====
// first stage: ring radius and vertex phase
// depends on crvg_pkg
`default_nettype none

module crvg_front (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire crvg_pkg::cfg_t                      cfg,
    input  wire logic [crvg_pkg::RING_W-1:0]         ring_index,
    input  wire logic [crvg_pkg::VERTEX_W-1:0]       vertex_index,
    output logic signed [crvg_pkg::RADIUS_W-1:0]     radius,
    output logic [crvg_pkg::PHASE_W-1:0]             phase
);

    logic [crvg_pkg::RING_W-1:0]         ring_clamped;
    logic [19:0]                         ring_prod;
    logic [23:0]                         phase_prod;
    logic signed [crvg_pkg::RADIUS_W-1:0] radius_next;
    logic signed [crvg_pkg::RADIUS_W-1:0] radius_reg;
    logic [crvg_pkg::PHASE_W-1:0]         phase_next;
    logic [crvg_pkg::PHASE_W-1:0]         phase_reg;

    always_comb
    begin
        if (32'(ring_index) > 32'(crvg_pkg::MAX_RINGS - 1))
        begin
            ring_clamped = crvg_pkg::RING_W'(crvg_pkg::MAX_RINGS - 1);
        end
        else
        begin
            ring_clamped = ring_index;
        end
        ring_prod   = 20'(ring_clamped) * 20'(cfg.ring_step);
        phase_prod  = 24'(vertex_index) * 24'(cfg.angle_step);
        radius_next = signed'(crvg_pkg::RADIUS_W'(cfg.base_radius))
                    - signed'(crvg_pkg::RADIUS_W'(ring_prod));
        phase_next  = phase_prod[crvg_pkg::PHASE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            radius_reg <= radius_next;
            phase_reg  <= phase_next;
        end
    end

    assign radius = radius_reg;
    assign phase  = phase_reg;

endmodule

`default_nettype wire

// ===== rtl/core/crvg_sine_rom.sv =====
// quarter-wave sine rom with two registered read ports, sine and cosine
// depends on crvg_pkg (table contents built at elaboration)
`default_nettype none

module crvg_sine_rom (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic [crvg_pkg::PHASE_W-1:0]        phase,
    output logic signed [crvg_pkg::SIN_VAL_W-1:0]    sin_val,
    output logic signed [crvg_pkg::SIN_VAL_W-1:0]    cos_val
);

    localparam crvg_pkg::sine_rom_t SineRom = crvg_pkg::build_sine_rom();
    localparam int ProdW = crvg_pkg::OFFSET_W + crvg_pkg::SIN_IDX_W;
    localparam logic [crvg_pkg::SIN_IDX_W-1:0] Depth =
        crvg_pkg::SIN_IDX_W'(crvg_pkg::SINE_TABLE_DEPTH);

    logic [crvg_pkg::PHASE_W-1:0]    cos_phase;
    logic [ProdW-1:0]                sin_prod;
    logic [ProdW-1:0]                cos_prod;
    logic [crvg_pkg::SIN_IDX_W-1:0]  sin_j;
    logic [crvg_pkg::SIN_IDX_W-1:0]  cos_j;
    logic [crvg_pkg::SIN_IDX_W-1:0]  sin_addr;
    logic [crvg_pkg::SIN_IDX_W-1:0]  cos_addr;
    crvg_pkg::sine_mag_t             sin_mag_reg;
    crvg_pkg::sine_mag_t             cos_mag_reg;
    logic                            sin_neg_reg;
    logic                            cos_neg_reg;

    always_comb
    begin
        cos_phase = phase + crvg_pkg::PHASE_QUARTER;
        sin_prod  = ProdW'(phase[crvg_pkg::OFFSET_W-1:0])
                  * ProdW'(crvg_pkg::SINE_TABLE_DEPTH);
        cos_prod  = ProdW'(cos_phase[crvg_pkg::OFFSET_W-1:0])
                  * ProdW'(crvg_pkg::SINE_TABLE_DEPTH);
        sin_j     = sin_prod[ProdW-1:crvg_pkg::OFFSET_W];
        cos_j     = cos_prod[ProdW-1:crvg_pkg::OFFSET_W];
        sin_addr  = phase[crvg_pkg::OFFSET_W] ? (Depth - sin_j) : sin_j;
        cos_addr  = cos_phase[crvg_pkg::OFFSET_W] ? (Depth - cos_j) : cos_j;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_mag_reg <= SineRom[sin_addr];
            cos_mag_reg <= SineRom[cos_addr];
            sin_neg_reg <= phase[crvg_pkg::PHASE_W-1];
            cos_neg_reg <= cos_phase[crvg_pkg::PHASE_W-1];
        end
    end

    always_comb
    begin
        sin_val = signed'({1'b0, sin_mag_reg});
        cos_val = signed'({1'b0, cos_mag_reg});
        if (sin_neg_reg)
        begin
            sin_val = -signed'({1'b0, sin_mag_reg});
        end
        if (cos_neg_reg)
        begin
            cos_val = -signed'({1'b0, cos_mag_reg});
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/crvg_coord.sv =====
// back stages: radius products, rounding, center offset, aspect scaling, saturation
// depends on crvg_pkg
`default_nettype none

module crvg_coord (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire crvg_pkg::cfg_t                      cfg,
    input  wire logic signed [crvg_pkg::RADIUS_W-1:0]  radius,
    input  wire logic signed [crvg_pkg::SIN_VAL_W-1:0] sin_val,
    input  wire logic signed [crvg_pkg::SIN_VAL_W-1:0] cos_val,
    output logic signed [crvg_pkg::COORD_W-1:0]      x_coord,
    output logic signed [crvg_pkg::COORD_W-1:0]      y_coord
);

    localparam int ProdW  = crvg_pkg::RADIUS_W + crvg_pkg::SIN_VAL_W;
    localparam int SumW   = 24;
    localparam int ScaleW = 41;

    logic signed [ProdW-1:0]            px_next;
    logic signed [ProdW-1:0]            py_next;
    logic signed [ProdW-1:0]            px_reg;
    logic signed [ProdW-1:0]            py_reg;
    logic signed [ProdW-1:0]            px_rnd;
    logic signed [ProdW-1:0]            py_rnd;
    logic signed [SumW-1:0]             x_sum;
    logic signed [SumW-1:0]             ysum_next;
    logic signed [SumW-1:0]             ysum_reg;
    logic signed [crvg_pkg::COORD_W-1:0] x4_reg;
    logic signed [ScaleW-1:0]           scaled_next;
    logic signed [ScaleW-1:0]           scaled_reg;
    logic signed [crvg_pkg::COORD_W-1:0] x5_reg;
    logic signed [ScaleW-1:0]           scaled_rnd;
    logic signed [crvg_pkg::COORD_W-1:0] x_reg;
    logic signed [crvg_pkg::COORD_W-1:0] y_reg;

    always_comb
    begin
        px_next     = ProdW'(radius) * ProdW'(cos_val);
        py_next     = ProdW'(radius) * ProdW'(sin_val);
        px_rnd      = px_reg + ProdW'(8192);
        py_rnd      = py_reg + ProdW'(8192);
        x_sum       = SumW'(signed'(px_rnd[ProdW-1:14])) + SumW'(cfg.center_x);
        ysum_next   = SumW'(signed'(py_rnd[ProdW-1:14])) + SumW'(cfg.center_y);
        scaled_next = ScaleW'(ysum_reg) * signed'(ScaleW'(cfg.aspect_ratio));
        scaled_rnd  = scaled_reg + ScaleW'(2048);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg     <= px_next;
            py_reg     <= py_next;
            x4_reg     <= crvg_pkg::sat_coord(32'(x_sum));
            ysum_reg   <= ysum_next;
            x5_reg     <= x4_reg;
            scaled_reg <= scaled_next;
            x_reg      <= x5_reg;
            y_reg      <= crvg_pkg::sat_coord(32'(signed'(scaled_rnd[ScaleW-1:12])));
        end
    end

    assign x_coord = x_reg;
    assign y_coord = y_reg;

endmodule

`default_nettype wire

// ===== rtl/core/circle_ring_vertex_generator_top.sv =====
// throughput: one vertex per cycle; the whole pipeline holds while the output waits
// reset: clears the stage valid bits and loads the register defaults
// the sine table is a constant rom, so no fill pass follows reset
// top level: config registers, stage valid bits, stall control; uses crvg_pkg and
// crvg_front, crvg_sine_rom, crvg_coord
`default_nettype none

module circle_ring_vertex_generator_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [crvg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [crvg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [crvg_pkg::RING_W-1:0]         ring_index,
    input  wire logic [crvg_pkg::VERTEX_W-1:0]       vertex_index,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [crvg_pkg::COORD_W-1:0]      x_coord,
    output logic signed [crvg_pkg::COORD_W-1:0]      y_coord
);

    crvg_pkg::cfg_t                         cfg_reg;
    logic [crvg_pkg::PIPE_DEPTH-1:0]        valid_reg;
    logic                                   en;
    logic signed [crvg_pkg::RADIUS_W-1:0]   radius_s1;
    logic signed [crvg_pkg::RADIUS_W-1:0]   radius_s2_reg;
    logic [crvg_pkg::PHASE_W-1:0]           phase_s1;
    logic signed [crvg_pkg::SIN_VAL_W-1:0]  sin_val;
    logic signed [crvg_pkg::SIN_VAL_W-1:0]  cos_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= crvg_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                crvg_pkg::CFG_CENTER_X:     cfg_reg.center_x     <= signed'(cfg_wdata);
                crvg_pkg::CFG_CENTER_Y:     cfg_reg.center_y     <= signed'(cfg_wdata);
                crvg_pkg::CFG_BASE_RADIUS:  cfg_reg.base_radius  <= cfg_wdata[14:0];
                crvg_pkg::CFG_RING_STEP:    cfg_reg.ring_step    <= cfg_wdata[11:0];
                crvg_pkg::CFG_ASPECT_RATIO: cfg_reg.aspect_ratio <= cfg_wdata;
                crvg_pkg::CFG_ANGLE_STEP:   cfg_reg.angle_step   <= cfg_wdata[11:0];
                default:
                begin
                end
            endcase
        end
    end

    assign en        = !valid_reg[crvg_pkg::PIPE_DEPTH-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = valid_reg[crvg_pkg::PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[crvg_pkg::PIPE_DEPTH-2:0], in_valid};
        end
    end

    crvg_front u_front (
        .clk          (clk),
        .en           (en),
        .cfg          (cfg_reg),
        .ring_index   (ring_index),
        .vertex_index (vertex_index),
        .radius       (radius_s1),
        .phase        (phase_s1)
    );

    crvg_sine_rom u_sine_rom (
        .clk     (clk),
        .en      (en),
        .phase   (phase_s1),
        .sin_val (sin_val),
        .cos_val (cos_val)
    );

    // radius rides alongside the rom read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            radius_s2_reg <= radius_s1;
        end
    end

    crvg_coord u_coord (
        .clk     (clk),
        .en      (en),
        .cfg     (cfg_reg),
        .radius  (radius_s2_reg),
        .sin_val (sin_val),
        .cos_val (cos_val),
        .x_coord (x_coord),
        .y_coord (y_coord)
    );

endmodule

`default_nettype wire

// ===== rtl/core/crvg_checker.sv =====
// port-level checks for circle_ring_vertex_generator_top and the bind that attaches them
// no package dependency; sees the top-level handshake and coordinate ports only
`default_nettype none

module crvg_assertions (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [15:0] x_coord,
    input  wire logic [15:0] y_coord
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(x_coord) && $stable(y_coord))
    else $error("stalled output transfer changed");

    // input side only stalls while a result waits untaken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

    // an accepted item shows up after the pipeline depth when nothing stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready
            ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("accepted item did not reach the output");

endmodule

bind circle_ring_vertex_generator_top crvg_assertions u_crvg_assertions (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .x_coord   (x_coord),
    .y_coord   (y_coord)
);

`default_nettype wire
